// ===== rtl/first_fit_segment_allocator_core_defines.svh =====
// assertion macros for the segment allocator
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define FFSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal stays stable in the cycle after a condition
`define FFSA_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== rtl/ffsa_pkg.sv =====
`default_nettype none
package ffsa_pkg;
  localparam int MaxSegs = 16;
  localparam int Owners = 8;
  localparam int IdxW = $clog2(MaxSegs);
  localparam int CntW = $clog2(MaxSegs + 1);
  localparam logic [15:0] PoolReset = 16'd1000;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StNoFit = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StNoOwner = 3'd3;
  localparam logic [2:0] StHolds = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_OWN, S_FIT, S_SHR, S_GRANT, S_ADDR, S_JR, S_JRSH, S_JL, S_JLSH, S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_scan;   // scan index to 0, acc and len to 0
    logic scan_own;   // one step of owner search
    logic scan_fit;   // one step of fit search
    logic shr_init;   // scan index to table end before a split shift
    logic scan_addr;  // one step of address sum up to target
    logic shr_step;   // one step of right shift for split
    logic grant;      // mark target used, write sizes
    logic free_mark;  // clear used of target, latch len
    logic join_r;     // add target+1 into target
    logic join_l;     // add target into target-1, target moves left
    logic shl_step;   // one step of left shift after join
    logic set_status;
    logic [2:0] status;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;    // scan index reached end of table
    logic own_hit;     // current entry is the owner's
    logic fit_hit;     // current entry fits
    logic fit_exact;
    logic full;
    logic shr_end;
    logic shl_end;
    logic addr_end;
    logic right_free;  // target+1 exists and is free
    logic left_free;   // target>0 and target-1 free
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/ffsa_datapath.sv =====
`default_nettype none
module ffsa_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic in_load_i,
  input  wire logic [2:0] owner_i,
  input  wire logic [15:0] req_size_i,
  input  wire ffsa_pkg::ctl_t ctl_i,
  output ffsa_pkg::sts_t sts_o,
  output logic [2:0] status_o,
  output logic [15:0] start_addr_o,
  output logic [15:0] seg_len_o
);
  import ffsa_pkg::*;

  logic [15:0] size_q [MaxSegs];
  logic [MaxSegs-1:0] used_q;
  logic [2:0] own_q [MaxSegs];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] idx_q;   // scan / shift index
  logic [IdxW-1:0] tgt_q;   // chosen entry
  logic [2:0] who_q;
  logic [15:0] req_q, acc_q, len_q;
  logic [2:0] st_q;
  logic [IdxW-1:0] ix;
  logic [CntW-1:0] tgt_w;

  assign ix = idx_q[IdxW-1:0];
  assign tgt_w = CntW'(tgt_q);

  // status toward the controller
  always_comb begin
    sts_o.scan_end = (idx_q >= cnt_q);
    sts_o.own_hit = used_q[ix] && (own_q[ix] == who_q);
    sts_o.fit_hit = !used_q[ix] && (size_q[ix] >= req_q);
    sts_o.fit_exact = (size_q[ix] == req_q);
    sts_o.full = (cnt_q >= CntW'(MaxSegs));
    sts_o.shr_end = (idx_q <= tgt_w + CntW'(1));
    sts_o.shl_end = (idx_q >= cnt_q);
    sts_o.addr_end = (idx_q >= tgt_w);
    sts_o.right_free = (tgt_w + CntW'(1) < cnt_q) && !used_q[IdxW'(tgt_w + CntW'(1))];
    sts_o.left_free = (tgt_q != '0) && !used_q[tgt_q - IdxW'(1)];
  end

  // command registers and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      tgt_q <= '0;
      st_q <= StOk;
    end else begin
      if (ctl_i.clr_scan) idx_q <= '0;
      else if (ctl_i.shr_init) idx_q <= cnt_q;
      else if (ctl_i.scan_own || ctl_i.scan_fit || ctl_i.scan_addr || ctl_i.shl_step)
        idx_q <= idx_q + CntW'(1);
      else if (ctl_i.shr_step) idx_q <= idx_q - CntW'(1);
      else if (ctl_i.join_r || ctl_i.join_l)
        idx_q <= ctl_i.join_l ? tgt_w : tgt_w + CntW'(1);
      else if (ctl_i.grant) idx_q <= '0;
      if ((ctl_i.scan_own && sts_o.own_hit) || (ctl_i.scan_fit && sts_o.fit_hit))
        tgt_q <= ix;
      else if (ctl_i.join_l) tgt_q <= tgt_q - IdxW'(1);
      if (ctl_i.set_status) st_q <= ctl_i.status;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      who_q <= owner_i;
      req_q <= req_size_i;
    end
    if (ctl_i.clr_scan) acc_q <= '0;
    else if (ctl_i.scan_addr && !sts_o.addr_end) acc_q <= acc_q + size_q[ix];
    if (ctl_i.clr_scan) len_q <= '0;
    else if (ctl_i.grant) len_q <= req_q;
    else if (ctl_i.free_mark) len_q <= size_q[tgt_q];
  end

  // segment table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSegs; i++) size_q[i] <= '0;
      size_q[0] <= PoolReset;
      used_q <= '0;
      cnt_q <= CntW'(1);
    end else if (cfg_we_i) begin
      for (int i = 0; i < MaxSegs; i++) size_q[i] <= '0;
      size_q[0] <= cfg_data_i;
      used_q <= '0;
      cnt_q <= CntW'(1);
    end else begin
      if (ctl_i.shr_step) begin
        size_q[ix] <= size_q[ix - IdxW'(1)];
        used_q[ix] <= used_q[ix - IdxW'(1)];
      end
      if (ctl_i.grant) begin
        used_q[tgt_q] <= 1'b1;
        if (size_q[tgt_q] != req_q) begin
          size_q[tgt_q] <= req_q;
          size_q[tgt_q + IdxW'(1)] <= size_q[tgt_q] - req_q;
          used_q[tgt_q + IdxW'(1)] <= 1'b0;
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (ctl_i.free_mark) used_q[tgt_q] <= 1'b0;
      if (ctl_i.join_r) begin
        size_q[tgt_q] <= size_q[tgt_q] + size_q[tgt_q + IdxW'(1)];
        cnt_q <= cnt_q - CntW'(1);
      end
      if (ctl_i.join_l) begin
        size_q[tgt_q - IdxW'(1)] <= size_q[tgt_q - IdxW'(1)] + size_q[tgt_q];
        cnt_q <= cnt_q - CntW'(1);
      end
      if (ctl_i.shl_step) begin
        if (sts_o.shl_end) begin
          size_q[ix] <= '0;
          used_q[ix] <= 1'b0;
        end else begin
          size_q[ix] <= size_q[ix + IdxW'(1)];
          used_q[ix] <= used_q[ix + IdxW'(1)];
        end
      end
    end
  end

  // owner ids have undefined reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.shr_step) own_q[ix] <= own_q[ix - IdxW'(1)];
    if (ctl_i.grant) own_q[tgt_q] <= who_q;
    if (ctl_i.shl_step && !sts_o.shl_end) own_q[ix] <= own_q[ix + IdxW'(1)];
  end

  assign status_o = st_q;
  assign start_addr_o = (st_q == StOk) ? acc_q : '0;
  assign seg_len_o = (st_q == StOk) ? len_q : '0;
endmodule
`default_nettype wire

// ===== rtl/ffsa_ctrl.sv =====
`default_nettype none
module ffsa_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic cmd_i,
  input  wire logic [2:0] owner_i,
  input  wire logic [15:0] req_size_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  input  wire ffsa_pkg::sts_t sts_i,
  output ffsa_pkg::ctl_t ctl_o
);
  import ffsa_pkg::*;

  state_e state_q, state_d;
  logic cmd_q, cmd_d, zero_q, zero_d, bad_q, bad_d;
  logic [2:0] own_unused;

  assign own_unused = owner_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q <= 1'b0;
      zero_q <= 1'b0;
      bad_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmd_q <= cmd_d;
      zero_q <= zero_d;
      bad_q <= bad_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    zero_d = zero_q;
    bad_d = bad_q;
    ctl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = cmd_i;
          zero_d = (req_size_i == '0);
          bad_d = (32'(own_unused) >= Owners);
          ctl_o.clr_scan = 1'b1;
          state_d = S_OWN;
        end
      end
      S_OWN: begin
        if (bad_q) begin
          ctl_o.set_status = 1'b1;
          ctl_o.status = StNoOwner;
          state_d = S_DONE;
        end else if (!sts_i.scan_end && sts_i.own_hit) begin
          ctl_o.scan_own = 1'b1;
          if (!cmd_q) begin
            ctl_o.set_status = 1'b1;
            ctl_o.status = StHolds;
            state_d = S_DONE;
          end else begin
            // restart the index for the address walk
            ctl_o.clr_scan = 1'b1;
            state_d = S_JR;
          end
        end else if (sts_i.scan_end) begin
          ctl_o.clr_scan = 1'b1;
          if (cmd_q) begin
            ctl_o.set_status = 1'b1;
            ctl_o.status = StNoOwner;
            state_d = S_DONE;
          end else if (zero_q) begin
            ctl_o.set_status = 1'b1;
            ctl_o.status = StNoFit;
            state_d = S_DONE;
          end else begin
            state_d = S_FIT;
          end
        end else begin
          ctl_o.scan_own = 1'b1;
        end
      end
      S_FIT: begin
        if (sts_i.scan_end) begin
          ctl_o.set_status = 1'b1;
          ctl_o.status = StNoFit;
          state_d = S_DONE;
        end else if (sts_i.fit_hit) begin
          ctl_o.scan_fit = 1'b1;
          if (sts_i.fit_exact) begin
            state_d = S_GRANT;
          end else if (sts_i.full) begin
            ctl_o.set_status = 1'b1;
            ctl_o.status = StFull;
            state_d = S_DONE;
          end else begin
            ctl_o.shr_init = 1'b1;
            state_d = S_SHR;
          end
        end else begin
          ctl_o.scan_fit = 1'b1;
        end
      end
      S_SHR: begin
        // open a slot after the target, walking down from the table end
        if (sts_i.shr_end) state_d = S_GRANT;
        else ctl_o.shr_step = 1'b1;
      end
      S_GRANT: begin
        ctl_o.grant = 1'b1;
        ctl_o.set_status = 1'b1;
        ctl_o.status = StOk;
        state_d = S_ADDR;
      end
      S_ADDR: begin
        if (sts_i.addr_end) state_d = cmd_q ? S_JRSH : S_DONE;
        else ctl_o.scan_addr = 1'b1;
      end
      S_JR: begin
        ctl_o.free_mark = 1'b1;
        ctl_o.set_status = 1'b1;
        ctl_o.status = StOk;
        ctl_o.clr_scan = 1'b0;
        state_d = S_ADDR;
      end
      S_JRSH: begin
        if (sts_i.right_free) begin
          ctl_o.join_r = 1'b1;
          state_d = S_JL;
        end else if (sts_i.left_free) begin
          ctl_o.join_l = 1'b1;
          state_d = S_JLSH;
        end else begin
          state_d = S_DONE;
        end
      end
      S_JL: begin
        if (!sts_i.shl_end) ctl_o.shl_step = 1'b1;
        else begin
          ctl_o.shl_step = 1'b1;
          state_d = S_JRSH;
        end
      end
      S_JLSH: begin
        if (!sts_i.shl_end) ctl_o.shl_step = 1'b1;
        else begin
          ctl_o.shl_step = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/first_fit_segment_allocator_core.sv =====
// First-fit segment allocator. One command (allocate or free) is taken at a time; it
// runs a sequencer that walks the segment table one entry per cycle: an owner search,
// a fit search, a right shift of the table for a split, a walk that sums sizes into the
// start address, and joins with left shifts on free. Writing the pool register
// reinitializes the table. The result is held until out_ready_i accepts it.
`default_nettype none
`include "first_fit_segment_allocator_core_defines.svh"
module first_fit_segment_allocator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic cmd_i,
  input  wire logic [2:0] owner_i,
  input  wire logic [15:0] req_size_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic [2:0] status_o,
  output logic [15:0] start_addr_o,
  output logic [15:0] seg_len_o
);
  import ffsa_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_load;

  assign in_load = in_valid_i && in_ready_o;

  ffsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .owner_i, .req_size_i,
    .out_valid_o, .out_ready_i,
    .sts_i (sts),
    .ctl_o (ctl)
  );

  ffsa_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_load_i (in_load), .owner_i, .req_size_i,
    .ctl_i (ctl), .sts_o (sts), .status_o, .start_addr_o, .seg_len_o
  );

  `FFSA_ASSERT(a_no_accept_busy, clk_i, rst_ni, out_valid_o |-> !in_ready_o,
    "input accepted while result pending")
  `FFSA_ASSERT_HOLD(a_result_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    status_o, "result changed while stalled")
endmodule
`default_nettype wire

// ===== verif/first_fit_segment_allocator_core_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module first_fit_segment_allocator_core_tb;
  import ffsa_pkg::*;

  localparam int StallLimit = 20000;
  localparam int DrainCycles = 4 * MaxSegs + 8;

  typedef struct packed {
    logic cmd;
    logic [2:0] owner;
    logic [15:0] req_size;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [15:0] start_addr;
    logic [15:0] seg_len;
  } alloc_rsp_t;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree = 1'b1;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic cmd_i;
  logic [2:0] owner_i;
  logic [15:0] req_size_i;
  logic out_valid_o, out_ready_i;
  logic [2:0] status_o;
  logic [15:0] start_addr_o, seg_len_o;

  first_fit_segment_allocator_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .cmd_i(cmd_i), .owner_i(owner_i), .req_size_i(req_size_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .status_o(status_o), .start_addr_o(start_addr_o), .seg_len_o(seg_len_o)
  );

  // shadow copy of the segment table
  logic [15:0] tbl_size [MaxSegs];
  logic tbl_used [MaxSegs];
  logic [2:0] tbl_owner [MaxSegs];
  int tbl_count;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int errors = 0;
  bit no_idle = 0;
  bit in_taken = 0;
  int idle_in = 0, idle_out = 0;
  int stall_cycles = 0;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void table_reset(input logic [15:0] pool);
    for (int i = 0; i < MaxSegs; i++) begin
      tbl_size[i] = '0;
      tbl_used[i] = 0;
      tbl_owner[i] = '0;
    end
    tbl_size[0] = pool;
    tbl_count = 1;
  endfunction

  function automatic int owner_slot(input logic [2:0] who);
    for (int k = 0; k < tbl_count; k++)
      if (tbl_used[k] && tbl_owner[k] == who) return k;
    return -1;
  endfunction

  function automatic logic [15:0] slot_addr(input int k);
    logic [15:0] a;
    a = '0;
    for (int t = 0; t < k; t++) a += tbl_size[t];
    return a;
  endfunction

  function automatic void merge_next(input int k);
    tbl_size[k] = tbl_size[k] + tbl_size[k + 1];
    tbl_used[k] = 0;
    for (int t = k + 1; t + 1 < tbl_count; t++) begin
      tbl_size[t] = tbl_size[t + 1];
      tbl_used[t] = tbl_used[t + 1];
      tbl_owner[t] = tbl_owner[t + 1];
    end
    tbl_size[tbl_count - 1] = '0;
    tbl_used[tbl_count - 1] = 0;
    tbl_owner[tbl_count - 1] = '0;
    tbl_count--;
  endfunction

  // works out the response to one command and updates the shadow table
  function automatic alloc_rsp_t predict_alloc(input alloc_req_t r);
    alloc_rsp_t p;
    int k;
    p = '{status: StOk, start_addr: '0, seg_len: '0};
    if (r.cmd == CmdAlloc) begin
      if (owner_slot(r.owner) >= 0) p.status = StHolds;
      else begin
        p.status = StNoFit;
        if (r.req_size != 0) begin
          for (k = 0; k < tbl_count; k++) begin
            if (tbl_used[k] || tbl_size[k] < r.req_size) continue;
            if (tbl_size[k] > r.req_size) begin
              if (tbl_count >= MaxSegs) begin
                p.status = StFull;
                break;
              end
              for (int t = tbl_count; t > k + 1; t--) begin
                tbl_size[t] = tbl_size[t - 1];
                tbl_used[t] = tbl_used[t - 1];
                tbl_owner[t] = tbl_owner[t - 1];
              end
              tbl_size[k + 1] = tbl_size[k] - r.req_size;
              tbl_used[k + 1] = 0;
              tbl_owner[k + 1] = '0;
              tbl_size[k] = r.req_size;
              tbl_count++;
            end
            tbl_used[k] = 1;
            tbl_owner[k] = r.owner;
            p.status = StOk;
            p.start_addr = slot_addr(k);
            p.seg_len = tbl_size[k];
            break;
          end
        end
      end
    end else begin
      k = owner_slot(r.owner);
      if (k < 0) p.status = StNoOwner;
      else begin
        p.start_addr = slot_addr(k);
        p.seg_len = tbl_size[k];
        tbl_used[k] = 0;
        if (k + 1 < tbl_count && !tbl_used[k + 1]) merge_next(k);
        if (k > 0 && !tbl_used[k - 1]) merge_next(k - 1);
      end
    end
    return p;
  endfunction

  // driver: one command transfer at a time
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_taken) pending_reqs.pop_front();
        if (idle_in > 0) begin
          idle_in <= idle_in - 1;
          in_valid_i <= 0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
          idle_in <= $urandom_range(0, 2);
          in_valid_i <= 0;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1;
          cmd_i <= pending_reqs[0].cmd;
          owner_i <= pending_reqs[0].owner;
          req_size_i <= pending_reqs[0].req_size;
        end else begin
          in_valid_i <= 0;
        end
      end
      // result side backpressure
      if (idle_out > 0) begin
        idle_out <= idle_out - 1;
        out_ready_i <= 0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        idle_out <= $urandom_range(0, 2);
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  // monitor: predict on command transfer, check on result transfer
  always @(posedge clk_i) begin
    alloc_rsp_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        expected_rsps.push_back(predict_alloc('{cmd: cmd_i, owner: owner_i,
                                                req_size: req_size_i}));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (status_o !== want.status) begin
            $error("status exp %0d got %0d", want.status, status_o);
            errors++;
          end
          if (start_addr_o !== want.start_addr) begin
            $error("start_addr exp %0d got %0d", want.start_addr, start_addr_o);
            errors++;
          end
          if (seg_len_o !== want.seg_len) begin
            $error("seg_len exp %0d got %0d", want.seg_len, seg_len_o);
            errors++;
          end
        end
      end
      if (stall_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic logic [15:0] rand_size(input logic [15:0] pool);
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return 16'($urandom());
    if (m == 1) return 16'(pool);
    if (m == 2) return 16'd0;
    return 16'($urandom_range(1, (pool > 16) ? pool / 6 : 2));
  endfunction

  task automatic push_cmd(input logic c, input logic [2:0] o, input logic [15:0] s);
    pending_reqs.push_back('{cmd: c, owner: o, req_size: s});
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_pool(input logic [15:0] pool);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_data_i <= pool;
    @(negedge clk_i);
    cfg_we_i <= 0;
    table_reset(pool);
  endtask

  initial begin
    logic [15:0] pools [6];
    logic [15:0] pool;
    pools = '{16'd1000, 16'd0, 16'd1, 16'd65535, 16'd40, 16'd300};
    rst_ni = 0;
    cfg_we_i = 0; cfg_data_i = '0;
    in_valid_i = 0; cmd_i = 0; owner_i = '0; req_size_i = '0;
    out_ready_i = 0;
    table_reset(PoolReset);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: reset pool, exact fit, split, holds, not found, merges
    push_cmd(CmdFree, 3'd0, 16'd5);
    push_cmd(CmdAlloc, 3'd0, 16'd0);
    push_cmd(CmdAlloc, 3'd0, 16'd65535);
    push_cmd(CmdAlloc, 3'd0, 16'd100);
    push_cmd(CmdAlloc, 3'd0, 16'd1);
    push_cmd(CmdAlloc, 3'd1, 16'd200);
    push_cmd(CmdAlloc, 3'd2, 16'd300);
    push_cmd(CmdFree, 3'd1, 16'hffff);
    push_cmd(CmdFree, 3'd0, 16'd0);
    push_cmd(CmdAlloc, 3'd7, 16'd300);
    push_cmd(CmdFree, 3'd2, 16'd0);
    push_cmd(CmdAlloc, 3'd3, 16'd400);
    push_cmd(CmdFree, 3'd7, 16'd0);
    push_cmd(CmdAlloc, 3'd4, 16'd600);
    push_cmd(CmdFree, 3'd3, 16'd0);
    push_cmd(CmdFree, 3'd4, 16'd0);
    push_cmd(CmdAlloc, 3'd5, 16'd1000);
    push_cmd(CmdFree, 3'd5, 16'd0);
    wait_idle();

    // allocate eight one-unit segments, free every other one, then allocate past the small gaps
    write_pool(16'd40);
    for (int i = 0; i < 8; i++) push_cmd(CmdAlloc, 3'(i), 16'd1);
    for (int i = 0; i < 8; i += 2) push_cmd(CmdFree, 3'(i), 16'd0);
    for (int i = 0; i < 8; i += 2) push_cmd(CmdAlloc, 3'(i), 16'd2);
    wait_idle();

    // random phases over several pool sizes
    for (int ph = 0; ph < 6; ph++) begin
      pool = pools[ph];
      write_pool(pool);
      if (ph == 5) no_idle = 1;
      for (int n = 0; n < 220; n++)
        push_cmd(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), rand_size(pool));
      wait_idle();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/ffsa_pkg.sv
rtl/ffsa_datapath.sv
rtl/ffsa_ctrl.sv
rtl/first_fit_segment_allocator_core.sv
verif/first_fit_segment_allocator_core_tb.sv
